>>> hw/rtl/ncelr_pkg.sv
// package for the noise channel envelope and length control block
// holds request and result types, channel state type and register map constants
// no dependencies
package ncelr_pkg;

    typedef enum logic [1:0] {
        OP_WRITE    = 2'd0,
        OP_READ     = 2'd1,
        OP_ENV_TICK = 2'd2,
        OP_LEN_TICK = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        REG_LENGTH   = 2'd0,
        REG_ENVELOPE = 2'd1,
        REG_POLY     = 2'd2,
        REG_CONTROL  = 2'd3
    } t_reg_idx;

    localparam logic [15:0] ADDR_BASE      = 16'hFF20;
    localparam logic [13:0] ADDR_PAGE      = ADDR_BASE[15:2];
    localparam logic [7:0]  LENGTH_READ    = 8'hFF;
    localparam logic [3:0]  VOLUME_MAX     = 4'd15;
    localparam logic [3:0]  VOLUME_RESET   = 4'd15;

    typedef struct packed {
        t_op         operation;
        logic [15:0] address;
        logic [7:0]  write_data;
    } t_req;

    typedef struct packed {
        logic [7:0] read_data;
        logic       access_error;
        logic       channel_on;
        logic [3:0] volume_level;
        logic       noise_restart;
        logic       noise_short_mode;
    } t_rsp;

    typedef struct packed {
        logic [7:0] length_reg;
        logic [7:0] envelope_reg;
        logic [7:0] poly_reg;
        logic [6:0] control_reg;
        logic [5:0] length_counter;
        logic [2:0] envelope_counter;
        logic [3:0] volume;
        logic       enabled;
    } t_state;

endpackage

>>> hw/rtl/noise_channel_envelope_length_regs.sv
// top level of the noise channel envelope, length and register control
// request register, channel state, result register; depends on ncelr_pkg, ncelr_core
//
// usage:
//   requests enter on i_in_valid / o_in_stall with payload i_in_data
//   (register write, register read, envelope tick or length tick), one
//   result per request leaves on o_out_valid / i_out_stall with o_out_data.
//   a request is taken at an edge where valid is high and stall is low.
//   a result passes through the request register, then the result
//   register, before it is presented.
//   throughput: one request per cycle while the receiver does not stall; the channel state is updated in the
//   single cycle a request moves from the request register to the result
//   register, so back-to-back requests see each other's effects in order.
//   when the receiver stalls, the result register holds its value; the
//   request register still takes one more request, after which o_in_stall
//   rises until the result is taken.
//   reset (synchronous, active low) empties both registers and clears the
//   channel registers and counters, with volume 15 and the channel off.
module noise_channel_envelope_length_regs
    import ncelr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_req i_in_data,
    output logic o_out_valid,
    input  logic i_out_stall,
    output t_rsp o_out_data
);

    logic   r_in_valid;
    t_req   r_in_req;
    logic   r_out_valid;
    t_rsp   r_out_rsp;
    t_state r_state;
    t_state n_state;
    t_rsp   n_rsp;
    logic   out_free;
    logic   advance;
    logic   take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign take       = i_in_valid && !o_in_stall;

    ncelr_core u_core (
        .i_req   (r_in_req),
        .i_state (r_state),
        .o_state (n_state),
        .o_rsp   (n_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '{volume: VOLUME_RESET, default: '0};
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_req <= i_in_data;
        end
        if (advance) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_rsp;

endmodule

>>> hw/rtl/ncelr_core.sv
// next-state and result logic for one request of the noise channel control
// depends on ncelr_pkg
module ncelr_core
    import ncelr_pkg::*;
(
    input  t_req   i_req,
    input  t_state i_state,
    output t_state o_state,
    output t_rsp   o_rsp
);

    logic       legal;
    t_reg_idx   idx;
    logic       trigger;
    logic [2:0] pace;
    logic [2:0] env_cnt_inc;
    logic [5:0] len_cnt_dec;
    t_state     nxt;

    assign legal = (i_req.address[15:2] == ADDR_PAGE);
    assign idx   = t_reg_idx'(i_req.address[1:0]);
    assign pace  = i_state.envelope_reg[2:0];
    assign env_cnt_inc = i_state.envelope_counter + 3'd1;

    always_comb begin
        nxt         = i_state;
        trigger     = 1'b0;
        len_cnt_dec = i_state.length_counter;
        o_rsp       = '0;
        unique case (i_req.operation)
            OP_WRITE: begin
                if (!legal) begin
                    o_rsp.access_error = 1'b1;
                end else begin
                    unique case (idx)
                        REG_LENGTH:   nxt.length_reg   = i_req.write_data;
                        REG_ENVELOPE: nxt.envelope_reg = i_req.write_data;
                        REG_POLY:     nxt.poly_reg     = i_req.write_data;
                        REG_CONTROL: begin
                            nxt.control_reg = i_req.write_data[6:0];
                            trigger         = i_req.write_data[7];
                        end
                        default: ;
                    endcase
                end
            end
            OP_READ: begin
                if (!legal) begin
                    o_rsp.access_error = 1'b1;
                end else begin
                    unique case (idx)
                        REG_LENGTH:   o_rsp.read_data = LENGTH_READ;
                        REG_ENVELOPE: o_rsp.read_data = i_state.envelope_reg;
                        REG_POLY:     o_rsp.read_data = i_state.poly_reg;
                        REG_CONTROL:  o_rsp.read_data = {1'b0, i_state.control_reg[6], 6'd0};
                        default: ;
                    endcase
                end
            end
            OP_ENV_TICK: begin
                if (pace != 3'd0) begin
                    if (env_cnt_inc >= pace) begin
                        nxt.envelope_counter = 3'd0;
                        if (!i_state.envelope_reg[3]) begin
                            if (i_state.volume != 4'd0) begin
                                nxt.volume = i_state.volume - 4'd1;
                            end
                        end else begin
                            if (i_state.volume != VOLUME_MAX) begin
                                nxt.volume = i_state.volume + 4'd1;
                            end
                        end
                    end else begin
                        nxt.envelope_counter = env_cnt_inc;
                    end
                end
            end
            OP_LEN_TICK: begin
                if (i_state.enabled) begin
                    if (i_state.length_counter != 6'd0) begin
                        len_cnt_dec = i_state.length_counter - 6'd1;
                    end
                    nxt.length_counter = len_cnt_dec;
                    if (i_state.control_reg[6] && (len_cnt_dec == 6'd0)) begin
                        nxt.enabled = 1'b0;
                    end
                end
            end
            default: ;
        endcase

        // trigger: channel on, envelope counter clear, volume reload, empty length counter reload
        if (trigger) begin
            nxt.enabled          = 1'b1;
            nxt.envelope_counter = 3'd0;
            nxt.volume           = i_state.envelope_reg[7:4];
            if (i_state.length_counter == 6'd0) begin
                nxt.length_counter = ~i_state.length_reg[5:0];
            end
        end

        o_rsp.channel_on       = nxt.enabled;
        o_rsp.volume_level     = nxt.volume;
        o_rsp.noise_restart    = trigger;
        o_rsp.noise_short_mode = nxt.poly_reg[3];
    end

    assign o_state = nxt;

endmodule

>>> hw/rtl/ncelr_checker.sv
// port checker for the noise channel control block, bound to the top level
// depends on ncelr_pkg
module ncelr_checker
    import ncelr_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_stall,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_rsp o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

    // reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // a trigger always leaves the channel on
    a_restart_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.noise_restart |-> o_out_data.channel_on)
        else $error("restart without channel on");

    // a bad access reads zero and never triggers
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.access_error |->
            (o_out_data.read_data == 8'd0) && !o_out_data.noise_restart)
        else $error("bad access with side effects");

    // a new result only follows a request taken through the request and result registers
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !$past(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without request");

endmodule

bind noise_channel_envelope_length_regs ncelr_checker u_ncelr_checker (.*);
